// ===== hdl/srwd_pkg.sv =====
package srwd_pkg;

  // field widths
  localparam int WORD_W    = 32;
  localparam int WIDTH_W   = 10;
  localparam int ROWS_W    = 8;
  localparam int PAL_W     = 7;
  localparam int PX_W      = 9;
  localparam int PY_W      = 8;
  localparam int PEN_W     = 4;
  localparam int ADDR_W    = 11;
  localparam int GREY_W    = 8;
  localparam int COL_W     = 12;
  localparam int ROW_W     = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 10;

  // sizing constants
  localparam int MAX_WIDTH     = 512;
  localparam int MAX_ROWS      = 256;
  localparam int PALETTE_COUNT = 128;
  localparam int PIX_PER_WORD  = 8;
  localparam int IDX_W         = 3;

  localparam logic [COL_W-1:0]  COL_MAX   = {COL_W{1'b1}};
  localparam logic [ROW_W-1:0]  ROW_MAX   = {ROW_W{1'b1}};
  localparam logic [WORD_W-1:0] SKIP_WORD = 32'h0000_00F0;
  localparam logic [PEN_W-1:0]  PEN_CLEAR = 4'h0;
  localparam logic [PEN_W-1:0]  PEN_OPAQ  = 4'hF;
  localparam logic [GREY_W-1:0] GREY_TOP  = 8'hFF;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPRITE_WIDTH   = 3'd0,
    CFG_ROWS_MINUS_ONE = 3'd1,
    CFG_MIRROR         = 3'd2,
    CFG_USE_PALETTE    = 3'd3,
    CFG_PALETTE_NUMBER = 3'd4
  } cfg_idx_t;

  // one result
  typedef struct packed {
    logic [PX_W-1:0]   pixel_x;
    logic [PY_W-1:0]   pixel_y;
    logic              visible;
    logic [PEN_W-1:0]  pen;
    logic [ADDR_W-1:0] palette_address;
    logic [GREY_W-1:0] grey_level;
    logic              colour_from_palette;
    logic              last;
    logic              sprite_done;
  } pixel_t;

endpackage

// ===== hdl/srwd_word_if.sv =====
interface srwd_word_if import srwd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] sprite_word;
  logic              first_word;

  modport source (output valid, output sprite_word, output first_word, input ready);
  modport sink   (input valid, input sprite_word, input first_word, output ready);
endinterface

// ===== hdl/srwd_pixel_if.sv =====
interface srwd_pixel_if import srwd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PX_W-1:0]   pixel_x;
  logic [PY_W-1:0]   pixel_y;
  logic              visible;
  logic [PEN_W-1:0]  pen;
  logic [ADDR_W-1:0] palette_address;
  logic [GREY_W-1:0] grey_level;
  logic              colour_from_palette;
  logic              last;
  logic              sprite_done;

  modport source (output valid, output pixel_x, output pixel_y, output visible, output pen,
                  output palette_address, output grey_level, output colour_from_palette,
                  output last, output sprite_done, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input visible, input pen,
                  input palette_address, input grey_level, input colour_from_palette,
                  input last, input sprite_done, output ready);
endinterface

// ===== hdl/srwd_cfg_if.sv =====
interface srwd_cfg_if import srwd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/sprite_row_word_decoder.sv =====
// sprite row word decoder
//
// words: one request carries a 32-bit sprite word (eight 4-bit pens, first
//   pen in bits 31:28) and first_word, which restarts column, row and done.
// pixels: eight results per word in pen order, last set on the eighth; a
//   skip word at a row start or any word after the sprite is done gives one result only.
// cfg: register writes, always accepted; index 0 width, 1 rows minus one,
//   2 mirror, 3 use palette, 4 palette number. Write only while idle.
//
// path: a word is latched into the work register at acceptance, then its
//   first pixel moves to the output register, which drives the pixels
//   channel directly.
// throughput: the output register takes one pixel a cycle while pixels.ready
//   allows it; the next word is accepted in the cycle its last pixel moves to
//   the output register.
// stall: when pixels.ready is low the output register holds its result and
//   the work register holds its word; words.ready stays low until it frees.
// reset: rst clears all configuration registers, column, row, done and
//   both valid flags.
module sprite_row_word_decoder import srwd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  srwd_word_if.sink           words,
  srwd_pixel_if.source        pixels,
  srwd_cfg_if.sink            cfg
);

  // configuration registers
  logic [WIDTH_W-1:0] sprite_width;
  logic [ROWS_W-1:0]  rows_minus_one;
  logic               mirror;
  logic               use_palette;
  logic [PAL_W-1:0]   palette_number;

  // sprite state
  logic [COL_W-1:0] column_count, column_count_next;
  logic [ROW_W-1:0] row_count, row_count_next;
  logic             done_flag, done_flag_next;

  // work register, one word in flight
  logic              work_valid;
  logic [WORD_W-1:0] work_word;
  logic [COL_W-1:0]  work_col;
  logic [PY_W-1:0]   work_row;
  logic              work_done;
  logic              work_skip;
  logic [IDX_W-1:0]  work_idx;

  // output register
  logic   out_valid;
  pixel_t out_pix, pix_next;

  logic word_fire, step, step_last;
  logic [COL_W-1:0] col_start;
  logic [ROW_W-1:0] row_start, row_inc;
  logic             done_start, skip_now, row_end;

  assign cfg.ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_width   <= '0;
      rows_minus_one <= '0;
      mirror         <= 1'b0;
      use_palette    <= 1'b0;
      palette_number <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_SPRITE_WIDTH:   sprite_width   <= cfg.data[WIDTH_W-1:0];
        CFG_ROWS_MINUS_ONE: rows_minus_one <= cfg.data[ROWS_W-1:0];
        CFG_MIRROR:         mirror         <= cfg.data[0];
        CFG_USE_PALETTE:    use_palette    <= cfg.data[0];
        CFG_PALETTE_NUMBER: palette_number <= cfg.data[PAL_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake between stages
  assign step      = work_valid && (!out_valid || pixels.ready);
  assign step_last = step && (work_skip || work_idx == IDX_W'(PIX_PER_WORD - 1));
  assign words.ready = !work_valid || step_last;
  assign word_fire   = words.valid && words.ready;

  // per-word state update
  always_comb begin
    col_start  = words.first_word ? '0 : column_count;
    row_start  = words.first_word ? '0 : row_count;
    done_start = words.first_word ? 1'b0 : done_flag;
    skip_now   = done_start || (col_start == '0 && words.sprite_word == SKIP_WORD);
    row_end    = words.sprite_word[7:4] == PEN_OPAQ;
    row_inc    = (row_start < ROW_MAX) ? row_start + ROW_W'(1) : row_start;

    column_count_next = col_start;
    row_count_next    = row_start;
    done_flag_next    = done_start;
    if (!skip_now) begin
      if (row_end) begin
        column_count_next = '0;
        row_count_next    = row_inc;
        if (row_inc >= ({1'b0, rows_minus_one} + ROW_W'(1)) ||
            row_inc >= ROW_W'(MAX_ROWS)) begin
          done_flag_next = 1'b1;
        end
      end else if (col_start > COL_MAX - COL_W'(PIX_PER_WORD)) begin
        column_count_next = COL_MAX;
      end else begin
        column_count_next = col_start + COL_W'(PIX_PER_WORD);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      done_flag    <= 1'b0;
    end else if (word_fire) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      done_flag    <= done_flag_next;
    end
  end

  // work register
  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
      work_idx   <= '0;
    end else if (word_fire) begin
      work_valid <= 1'b1;
      work_idx   <= '0;
    end else if (step_last) begin
      work_valid <= 1'b0;
    end else if (step) begin
      work_idx <= work_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (word_fire) begin
      work_word <= words.sprite_word;
      work_col  <= col_start;
      work_row  <= row_start[PY_W-1:0];
      work_done <= done_flag_next;
      work_skip <= skip_now;
    end
  end

  // pixel datapath
  logic [PEN_W-1:0]     pen_sel;
  logic [WORD_W-1:0]    word_shift;
  logic [COL_W:0]       col_sum;
  logic [COL_W-1:0]     col;
  logic signed [COL_W+1:0] tgt;
  logic                 tgt_in, pen_draw;
  logic [PAL_W-1:0]     pal_blk;

  always_comb begin
    word_shift = work_word << {work_idx, 2'b00};
    pen_sel    = work_skip ? PEN_CLEAR : word_shift[WORD_W-1 -: PEN_W];
    col_sum    = {1'b0, work_col} + (COL_W+1)'(work_idx);
    col        = col_sum[COL_W] ? COL_MAX : col_sum[COL_W-1:0];
    tgt        = mirror ? $signed({4'b0000, sprite_width}) - $signed({2'b00, col})
                        : $signed({2'b00, col});
    tgt_in     = !tgt[COL_W+1] && tgt[COL_W:PX_W] == '0;
    pen_draw   = pen_sel != PEN_CLEAR && pen_sel != PEN_OPAQ;
    pal_blk    = (32'(palette_number) >= 32'(PALETTE_COUNT)) ?
                 PAL_W'(PALETTE_COUNT - 1) : palette_number;

    pix_next.pixel_x = (tgt_in && !work_skip) ? tgt[PX_W-1:0] : '0;
    pix_next.pixel_y = work_row;
    pix_next.visible = !work_skip && tgt_in && pen_draw &&
                       tgt[COL_W:0] < {3'b000, sprite_width};
    pix_next.pen     = pen_sel;
    pix_next.palette_address     = {pal_blk, pen_sel};
    pix_next.grey_level          = GREY_TOP - {pen_sel, 4'b0000};
    pix_next.colour_from_palette = use_palette;
    pix_next.last                = work_skip || work_idx == IDX_W'(PIX_PER_WORD - 1);
    pix_next.sprite_done         = work_done;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (pixels.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_pix <= pix_next;
    end
  end

  assign pixels.valid               = out_valid;
  assign pixels.pixel_x             = out_pix.pixel_x;
  assign pixels.pixel_y             = out_pix.pixel_y;
  assign pixels.visible             = out_pix.visible;
  assign pixels.pen                 = out_pix.pen;
  assign pixels.palette_address     = out_pix.palette_address;
  assign pixels.grey_level          = out_pix.grey_level;
  assign pixels.colour_from_palette = out_pix.colour_from_palette;
  assign pixels.last                = out_pix.last;
  assign pixels.sprite_done         = out_pix.sprite_done;

endmodule

// ===== tb/srwd_tb_pkg.sv =====
package srwd_tb_pkg;
  import srwd_pkg::*;

  // tracks the decoder state and holds the pixels each accepted word should produce
  class pixel_tracker;
    logic [WIDTH_W-1:0] sprite_width;
    logic [ROWS_W-1:0]  rows_minus_one;
    logic               mirror;
    logic               use_palette;
    logic [PAL_W-1:0]   palette_number;

    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
    logic               done;

    pixel_t             pending_pixels[$];

    int unsigned words_seen;
    int unsigned pixels_checked;
    int unsigned visible_seen;
    int unsigned single_words;
    int unsigned mismatches;

    function new();
      sprite_width   = '0;
      rows_minus_one = '0;
      mirror         = 1'b0;
      use_palette    = 1'b0;
      palette_number = '0;
      column         = '0;
      row            = '0;
      done           = 1'b0;
      words_seen     = 0;
      pixels_checked = 0;
      visible_seen   = 0;
      single_words   = 0;
      mismatches     = 0;
    endfunction

    // register write accepted on the config channel
    function void write_reg(cfg_idx_t idx, logic [CFG_DAT_W-1:0] value);
      case (idx)
        CFG_SPRITE_WIDTH:   sprite_width   = value[WIDTH_W-1:0];
        CFG_ROWS_MINUS_ONE: rows_minus_one = value[ROWS_W-1:0];
        CFG_MIRROR:         mirror         = value[0];
        CFG_USE_PALETTE:    use_palette    = value[0];
        CFG_PALETTE_NUMBER: palette_number = value[PAL_W-1:0];
        default: ;
      endcase
    endfunction

    // colour fields follow from the pen and the current settings
    function pixel_t make_pixel(logic [PX_W-1:0] x, logic vis, logic [PEN_W-1:0] p,
                                logic lst);
      pixel_t      px;
      int unsigned blk;
      blk = (palette_number >= PALETTE_COUNT) ? PALETTE_COUNT - 1 : palette_number;
      px.pixel_x             = x;
      px.pixel_y             = row[PY_W-1:0];
      px.visible             = vis;
      px.pen                 = p;
      px.palette_address     = ADDR_W'(blk * 16 + p);
      px.grey_level          = GREY_TOP - {p, 4'h0};
      px.colour_from_palette = use_palette;
      px.last                = lst;
      px.sprite_done         = done;
      return px;
    endfunction

    // word request accepted: work out its pixels and advance the counters
    function void accept_word(logic [WORD_W-1:0] w, logic first);
      pixel_t            word_pix[PIX_PER_WORD];
      logic [COL_W-1:0]  col;
      logic [PEN_W-1:0]  p;
      logic [PX_W-1:0]   x;
      logic              vis;
      int                tgt;
      int                i;
      words_seen++;
      if (first) begin
        column = '0;
        row    = '0;
        done   = 1'b0;
      end
      // finished sprite or skip word at a row start: one blank pixel
      if (done || (column == '0 && w == SKIP_WORD)) begin
        pending_pixels.push_back(make_pixel('0, 1'b0, PEN_CLEAR, 1'b1));
        single_words++;
        return;
      end
      for (i = 0; i < PIX_PER_WORD; i++) begin
        p = w[WORD_W-1-PEN_W*i -: PEN_W];
        if (int'(column) + i > int'(COL_MAX))
          col = COL_MAX;
        else
          col = column + COL_W'(i);
        tgt = mirror ? int'(sprite_width) - int'(col) : int'(col);
        vis = tgt >= 0 && tgt < int'(sprite_width) && tgt < MAX_WIDTH &&
              p != PEN_CLEAR && p != PEN_OPAQ;
        x = (tgt >= 0 && tgt < MAX_WIDTH) ? PX_W'(tgt) : '0;
        word_pix[i] = make_pixel(x, vis, p, i == PIX_PER_WORD - 1);
      end
      // row end on an all-ones nibble in bits 7:4, else the column moves on
      if ((w & SKIP_WORD) == SKIP_WORD) begin
        column = '0;
        if (row < ROW_MAX)
          row++;
        if (int'(row) >= int'(rows_minus_one) + 1 || int'(row) >= MAX_ROWS)
          done = 1'b1;
      end else if (int'(column) + PIX_PER_WORD > int'(COL_MAX)) begin
        column = COL_MAX;
      end else begin
        column = column + COL_W'(PIX_PER_WORD);
      end
      // done reflects the state after the word
      for (i = 0; i < PIX_PER_WORD; i++) begin
        word_pix[i].sprite_done = done;
        pending_pixels.push_back(word_pix[i]);
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        if (mismatches < 50)
          $error("%s mismatch: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    // pixel accepted on the output channel: compare against the oldest expectation
    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        if (mismatches < 50)
          $error("unexpected pixel: x %0d y %0d pen %0h", got.pixel_x, got.pixel_y, got.pen);
        mismatches++;
        return;
      end
      want = pending_pixels.pop_front();
      pixels_checked++;
      if (got.visible === 1'b1)
        visible_seen++;
      compare_field("pixel_x", want.pixel_x, got.pixel_x);
      compare_field("pixel_y", want.pixel_y, got.pixel_y);
      compare_field("visible", want.visible, got.visible);
      compare_field("pen", want.pen, got.pen);
      compare_field("palette_address", want.palette_address, got.palette_address);
      compare_field("grey_level", want.grey_level, got.grey_level);
      compare_field("colour_from_palette", want.colour_from_palette,
                    got.colour_from_palette);
      compare_field("last", want.last, got.last);
      compare_field("sprite_done", want.sprite_done, got.sprite_done);
    endfunction
  endclass

endpackage

// ===== tb/tb_sprite_row_word_decoder.sv =====
module tb_sprite_row_word_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import srwd_pkg::*;
  import srwd_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic gaps_on;

  int unsigned cycle_count   = 0;
  int unsigned settings_used = 0;

  pixel_tracker tracker = new();

  srwd_word_if  words();
  srwd_pixel_if pixels();
  srwd_cfg_if   cfg();

  sprite_row_word_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .words  (words),
    .pixels (pixels),
    .cfg    (cfg)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // pixel sink: check accepted requests, stall at random while gaps are on
  initial begin
    pixels.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pixels.valid && pixels.ready)
        tracker.check_pixel({pixels.pixel_x, pixels.pixel_y, pixels.visible, pixels.pen,
                             pixels.palette_address, pixels.grey_level,
                             pixels.colour_from_palette, pixels.last,
                             pixels.sprite_done});
      pixels.ready <= gaps_on ? ($urandom_range(99) >= 14) : 1'b1;
    end
  end

  // one word request, with an optional random gap ahead of it
  task automatic send_word(input logic [WORD_W-1:0] w, input logic first);
    if (gaps_on) begin
      while ($urandom_range(99) < 14) begin
        words.valid <= 1'b0;
        @(posedge clk);
      end
    end
    words.valid       <= 1'b1;
    words.sprite_word <= w;
    words.first_word  <= first;
    @(posedge clk);
    while (!words.ready) @(posedge clk);
    tracker.accept_word(w, first);
  endtask

  // wait until every expected pixel has come out, then let the pipe settle
  task automatic drain_words();
    words.valid <= 1'b0;
    while (tracker.pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    tracker.write_reg(idx, value);
  endtask

  task automatic program_regs(input logic [CFG_DAT_W-1:0] width,
                              input logic [CFG_DAT_W-1:0] rows,
                              input logic [CFG_DAT_W-1:0] mir,
                              input logic [CFG_DAT_W-1:0] pal_en,
                              input logic [CFG_DAT_W-1:0] pal_num);
    write_reg(CFG_SPRITE_WIDTH, width);
    write_reg(CFG_ROWS_MINUS_ONE, rows);
    write_reg(CFG_MIRROR, mir);
    write_reg(CFG_USE_PALETTE, pal_en);
    write_reg(CFG_PALETTE_NUMBER, pal_num);
    cfg.valid <= 1'b0;
    settings_used++;
  endtask

  // mostly well-formed sprites with random pens, plus noise and skip words
  task automatic random_sprites(input int unsigned count);
    int unsigned       sent;
    int unsigned       nrows;
    int unsigned       row_len;
    int unsigned       r;
    int unsigned       k;
    int unsigned       pick;
    logic [WORD_W-1:0] w;
    logic              first;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // noise: any word, any restart flag
        send_word($urandom, 1'($urandom_range(1)));
        sent++;
      end else if (pick < 14) begin
        // skip word, mostly without restart
        send_word(SKIP_WORD, $urandom_range(3) == 0);
        sent++;
      end else begin
        // sprite that sometimes runs one row past its row count, now and then without the restart
        first = ($urandom_range(9) != 0);
        nrows = int'(tracker.rows_minus_one) + 1;
        if (nrows > 5)
          nrows = $urandom_range(5, 1);
        nrows += $urandom_range(1);
        for (r = 0; r < nrows && sent < count; r++) begin
          row_len = ($urandom_range(11) == 0) ? $urandom_range(70, 60) : $urandom_range(4, 1);
          for (k = 0; k < row_len && sent < count; k++) begin
            w = $urandom;
            w[7:4] = (k == row_len - 1) ? PEN_OPAQ : PEN_W'($urandom_range(14));
            send_word(w, first);
            first = 1'b0;
            sent++;
          end
        end
      end
    end
  endtask

  // one row long enough to drive the column counter into saturation
  task automatic long_row(input int unsigned n);
    int unsigned       k;
    logic [WORD_W-1:0] w;
    for (k = 0; k <= n; k++) begin
      w = $urandom;
      w[7:4] = (k == n) ? PEN_OPAQ : PEN_W'($urandom_range(14));
      send_word(w, k == 0);
    end
  endtask

  // stimulus
  initial begin
    int unsigned          p;
    logic [CFG_DAT_W-1:0] width;
    logic [CFG_DAT_W-1:0] rows;
    logic [CFG_DAT_W-1:0] pal_num;

    words.valid       <= 1'b0;
    words.sprite_word <= '0;
    words.first_word  <= 1'b0;
    cfg.valid         <= 1'b0;
    cfg.index         <= CFG_SPRITE_WIDTH;
    cfg.data          <= '0;
    gaps_on           <= 1'b1;
    rst               <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: skip word, row ends, done, restart, full palette block
    program_regs(10'd512, 10'd2, 10'd0, 10'd1, 10'd127);
    send_word(32'h0000_00F0, 1'b1);
    send_word(32'h0123_456E, 1'b0);
    send_word(32'hFEDC_BA98, 1'b0);
    send_word(32'h89AB_CDF0, 1'b0);
    send_word(32'h0000_00F0, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h1111_1111, 1'b0);
    send_word(32'h7777_77F7, 1'b0);
    send_word(32'h1234_5678, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    send_word(32'h0000_0000, 1'b0);
    drain_words();

    // directed: mirror drops the first pixel, one-row sprite, greyscale
    program_regs(10'd8, 10'd0, 10'd1, 10'd0, 10'd0);
    send_word(32'h1234_5678, 1'b1);
    send_word(32'hABCD_EFF1, 1'b1);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_00F0, 1'b1);
    drain_words();

    // random phases over a spread of settings
    for (p = 0; p < 8; p++) begin
      case (p)
        0, 5:    width = 10'd512;
        1:       width = 10'd0;
        4:       width = 10'd1023;
        2, 6:    width = CFG_DAT_W'($urandom_range(16, 1));
        default: width = CFG_DAT_W'($urandom_range(512, 1));
      endcase
      if (p == 0)
        rows = 10'd0;
      else if (p == 1 || p == 5)
        rows = 10'd255;
      else
        rows = CFG_DAT_W'($urandom_range(3));
      if (p == 0)
        pal_num = 10'd0;
      else if (p == 1)
        pal_num = 10'd127;
      else
        pal_num = CFG_DAT_W'($urandom_range(127));
      program_regs(width, rows, CFG_DAT_W'(p & 1), CFG_DAT_W'((p >> 1) & 1), pal_num);
      gaps_on <= (p != 3);
      random_sprites(54);
      drain_words();
    end

    // column saturation, no gaps on either side
    program_regs(10'd512, 10'd0, 10'd0, CFG_DAT_W'($urandom_range(1)),
                 CFG_DAT_W'($urandom_range(127)));
    gaps_on <= 1'b0;
    long_row(515);
    drain_words();

    $display("covered %0d words under %0d register settings: %0d pixels checked,",
             tracker.words_seen, settings_used, tracker.pixels_checked);
    $display("%0d of them visible, %0d single-result words, %0d mismatches",
             tracker.visible_seen, tracker.single_words, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending_pixels.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
